/* rtl/mmsc_pkg.sv */
// shared types and constants for the markov mixture sequence classifier
// no dependencies; every rtl file but mmsc_ram refers to it by scoped names
`timescale 1ns / 1ps

package mmsc_pkg;

  // default storage sizes
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_PAGES    = 64;
  localparam int COST_WIDTH   = 16;

  localparam int DATA_WIDTH = 32;
  localparam int ADDR_WIDTH = 3;

  // request codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_VISIT = 1'b1;

  // register selects, taken from paddr[2]
  localparam logic REG_CLUSTER_COUNT = 1'b0;
  localparam logic REG_PAGE_COUNT    = 1'b1;

  localparam logic [4:0] CLUSTER_COUNT_RST = 5'd16;
  localparam logic [6:0] PAGE_COUNT_RST    = 7'd64;

  typedef struct packed {
    logic        command;
    logic [3:0]  cluster_index;
    logic [5:0]  from_page;
    logic [5:0]  to_page;
    logic [15:0] log_cost;
    logic [6:0]  page_number;
    logic        first_of_seq;
    logic        last_of_seq;
  } req_t;

  typedef struct packed {
    logic [3:0]  best_cluster;
    logic [31:0] best_cost;
    logic [15:0] visit_count;
    logic        bad_page;
  } res_t;

  typedef struct packed {
    logic [4:0] cluster_count;
    logic [6:0] page_count;
  } cfg_t;

  // control from the sequence logic to the scoring engine
  typedef struct packed {
    logic start;  // launch a pass over the clusters
    logic score;  // add the transition cost during the pass
    logic last;   // report the minimum at the end of the pass
    logic clear;  // a new sequence begins: accumulators read as zero
  } pass_t;

endpackage

/* rtl/mmsc_ram.sv */
// generic single-write, single-read synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mmsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mmsc_cfg.sv */
// apb-style configuration registers: cluster count and page count
// depends on mmsc_pkg
`timescale 1ns / 1ps

module mmsc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmsc_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [mmsc_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [mmsc_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                              pready,
  output mmsc_pkg::cfg_t                    cfg_o
);

  logic [4:0] cluster_count_q, cluster_count_d;
  logic [6:0] page_count_q, page_count_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cluster_count_d = cluster_count_q;
    page_count_d    = page_count_q;
    if (wr_en) begin
      unique case (paddr[2])
        mmsc_pkg::REG_CLUSTER_COUNT: cluster_count_d = pwdata[4:0];
        mmsc_pkg::REG_PAGE_COUNT:    page_count_d    = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mmsc_pkg::REG_CLUSTER_COUNT: prdata = {27'd0, cluster_count_q};
      mmsc_pkg::REG_PAGE_COUNT:    prdata = {25'd0, page_count_q};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q <= mmsc_pkg::CLUSTER_COUNT_RST;
      page_count_q    <= mmsc_pkg::PAGE_COUNT_RST;
    end else begin
      cluster_count_q <= cluster_count_d;
      page_count_q    <= page_count_d;
    end
  end

  assign cfg_o.cluster_count = cluster_count_q;
  assign cfg_o.page_count    = page_count_q;

endmodule

/* rtl/mmsc_engine.sv */
// scoring engine: transition cost table, accumulator ram, per-cluster
// read-modify-write pass and running minimum; depends on mmsc_pkg, mmsc_ram
`timescale 1ns / 1ps

module mmsc_engine #(
  parameter int MAX_CLUSTERS = mmsc_pkg::MAX_CLUSTERS,
  parameter int MAX_PAGES    = mmsc_pkg::MAX_PAGES,
  parameter int COST_WIDTH   = mmsc_pkg::COST_WIDTH,
  localparam int CW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
  localparam int PW  = $clog2(MAX_PAGES),
  localparam int TD  = MAX_CLUSTERS * MAX_PAGES * MAX_PAGES,
  localparam int TAW = $clog2(TD)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // table load
  input  logic                  ld_we_i,
  input  logic [CW-1:0]         ld_cluster_i,
  input  logic [PW-1:0]         ld_from_i,
  input  logic [PW-1:0]         ld_to_i,
  input  logic [COST_WIDTH-1:0] ld_cost_i,
  // pass launch
  input  mmsc_pkg::pass_t       pass_i,
  input  logic [PW-1:0]         from_i,
  input  logic [PW-1:0]         to_i,
  input  logic [CW-1:0]         nlast_i,
  output logic                  busy_o,
  // minimum, shown for one cycle
  output logic                  out_vld_o,
  output logic [CW-1:0]         out_k_o,
  output logic [31:0]           out_cost_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] nlast_q;
  logic [PW-1:0] from_q, to_q;
  logic          score_q, last_q;
  logic          s2_vld_q;
  logic [CW-1:0] s2_k_q;
  logic [MAX_CLUSTERS-1:0] acc_vld_q, acc_vld_d;
  logic [CW-1:0] best_k_q, cand_k;
  logic [31:0]   best_cost_q, cand_cost;
  logic          out_vld_q;
  logic [CW-1:0] out_k_q;
  logic [31:0]   out_cost_q;

  logic [TAW-1:0]        tab_waddr, tab_raddr;
  logic [COST_WIDTH-1:0] tab_rdata;
  logic [31:0]           acc_rdata, acc_old, acc_add, acc_sat;
  logic [32:0]           acc_sum;
  logic                  take_new;

  // flat table index: (cluster * pages + from) * pages + to
  assign tab_waddr = (TAW'(ld_cluster_i) * TAW'(MAX_PAGES) + TAW'(ld_from_i))
                     * TAW'(MAX_PAGES) + TAW'(ld_to_i);
  assign tab_raddr = (TAW'(k_q) * TAW'(MAX_PAGES) + TAW'(from_q))
                     * TAW'(MAX_PAGES) + TAW'(to_q);

  mmsc_ram #(
    .WIDTH (COST_WIDTH),
    .DEPTH (TD)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ld_we_i),
    .waddr_i (tab_waddr),
    .wdata_i (ld_cost_i),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  mmsc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_CLUSTERS)
  ) u_acc (
    .clk_i   (clk_i),
    .we_i    (s2_vld_q),
    .waddr_i (s2_k_q),
    .wdata_i (acc_sat),
    .raddr_i (k_q),
    .rdata_o (acc_rdata)
  );

  // second stage: add, saturate, write back, track minimum
  assign acc_old  = acc_vld_q[s2_k_q] ? acc_rdata : 32'd0;
  assign acc_add  = score_q ? 32'(tab_rdata) : 32'd0;
  assign acc_sum  = {1'b0, acc_old} + {1'b0, acc_add};
  assign acc_sat  = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
  assign take_new = (s2_k_q == '0) || (acc_sat < best_cost_q);
  assign cand_k    = take_new ? s2_k_q : best_k_q;
  assign cand_cost = take_new ? acc_sat : best_cost_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (pass_i.start) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        k_d = k_q + CW'(1);
        if (k_q == nlast_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    acc_vld_d = acc_vld_q;
    if (s2_vld_q) begin
      acc_vld_d[s2_k_q] = 1'b1;
    end
    if (pass_i.clear) begin
      acc_vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      s2_vld_q  <= 1'b0;
      acc_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      s2_vld_q  <= (state_q == ST_ISSUE);
      acc_vld_q <= acc_vld_d;
      out_vld_q <= (state_q == ST_DRAIN) && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pass_i.start) begin
      nlast_q <= nlast_i;
      from_q  <= from_i;
      to_q    <= to_i;
      score_q <= pass_i.score;
      last_q  <= pass_i.last;
    end
    s2_k_q <= k_q;
    if (s2_vld_q) begin
      best_k_q    <= cand_k;
      best_cost_q <= cand_cost;
    end
    if (state_q == ST_DRAIN) begin
      out_k_q    <= cand_k;
      out_cost_q <= cand_cost;
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign out_vld_o  = out_vld_q;
  assign out_k_o    = out_k_q;
  assign out_cost_o = out_cost_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_i.start |-> state_q == ST_IDLE)
    else $error("pass launched while engine busy");

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_we_i |-> state_q == ST_IDLE)
    else $error("table load during a pass");

  a_result_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $past(state_q == ST_DRAIN))
    else $error("result without a finished pass");

  a_drain_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |=> state_q == ST_IDLE)
    else $error("drain did not return to idle");

endmodule

/* rtl/markov_mixture_sequence_classifier.sv */
// top level of the markov mixture sequence classifier: request decode,
// sequence bookkeeping; depends on mmsc_pkg, mmsc_cfg, mmsc_engine
`timescale 1ns / 1ps

// A load request writes one transition cost into the table; busy stays
// low. A visit request that neither scores a transition nor ends its
// sequence starts no pass, and busy stays low as well. A visit that scores
// a transition or ends the sequence runs one read-modify-write of the
// accumulator ram per active cluster, and busy is high while that pass
// issues and drains. On the last visit the result appears on res_o with
// res_valid_o high for exactly one cycle, the first cycle with busy low
// again; the receiver cannot stall it and must take it then. Accumulators
// are cleared by per-cluster valid bits at a sequence start, so there is
// no clearing pass after reset; table entries read before they are loaded
// give undefined costs.
module markov_mixture_sequence_classifier #(
  parameter int MAX_CLUSTERS = mmsc_pkg::MAX_CLUSTERS,
  parameter int MAX_PAGES    = mmsc_pkg::MAX_PAGES,
  parameter int COST_WIDTH   = mmsc_pkg::COST_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  mmsc_pkg::req_t                  req_i,
  output logic                            res_valid_o,
  output mmsc_pkg::res_t                  res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mmsc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [mmsc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [mmsc_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready
);

  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int PW = $clog2(MAX_PAGES);

  mmsc_pkg::cfg_t  cfg;
  mmsc_pkg::pass_t pass;

  logic          accept, ld_acc, visit_acc, ld_ok, ld_we;
  logic          seq_new, page_ok, prev_ok, score;
  logic [PW-1:0] cur_page;
  logic [CW-1:0] nlast;
  logic [15:0]   visits_base;

  logic          seq_open_q, seq_open_d;
  logic          prev_vld_q, prev_vld_d;
  logic [PW-1:0] prev_page_q, prev_page_d;
  logic [15:0]   visits_q, visits_d;
  logic          err_q, err_d;

  logic          eng_busy, out_vld;
  logic [CW-1:0] out_k;
  logic [31:0]   out_cost;

  mmsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign accept    = start && !busy;
  assign ld_acc    = accept && (req_i.command == mmsc_pkg::CMD_LOAD);
  assign visit_acc = accept && (req_i.command == mmsc_pkg::CMD_VISIT);

  // loads outside the table are dropped
  assign ld_ok = (32'(req_i.cluster_index) < 32'(MAX_CLUSTERS)) &&
                 (32'(req_i.from_page) < 32'(MAX_PAGES)) &&
                 (32'(req_i.to_page) < 32'(MAX_PAGES));
  assign ld_we = ld_acc && ld_ok;

  always_comb begin
    if (cfg.cluster_count == 5'd0) begin
      nlast = '0;
    end else if (32'(cfg.cluster_count) > 32'(MAX_CLUSTERS)) begin
      nlast = CW'(MAX_CLUSTERS - 1);
    end else begin
      nlast = CW'(cfg.cluster_count - 5'd1);
    end
  end

  assign seq_new  = req_i.first_of_seq || !seq_open_q;
  assign page_ok  = (req_i.page_number != 7'd0) &&
                    (req_i.page_number <= cfg.page_count) &&
                    (32'(req_i.page_number) <= 32'(MAX_PAGES));
  assign cur_page = PW'(req_i.page_number - 7'd1);
  assign prev_ok  = !seq_new && prev_vld_q;
  assign score    = page_ok && prev_ok;

  assign visits_base = seq_new ? 16'd0 : visits_q;

  always_comb begin
    seq_open_d  = seq_open_q;
    prev_vld_d  = prev_vld_q;
    prev_page_d = prev_page_q;
    visits_d    = visits_q;
    err_d       = err_q;
    if (visit_acc) begin
      seq_open_d = !req_i.last_of_seq;
      // an invalid page breaks the chain on both sides
      prev_vld_d = page_ok;
      if (page_ok) begin
        prev_page_d = cur_page;
      end
      visits_d = (visits_base == 16'hFFFF) ? visits_base : visits_base + 16'd1;
      err_d    = (!seq_new && err_q) || !page_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_open_q  <= 1'b0;
      prev_vld_q  <= 1'b0;
      prev_page_q <= '0;
      visits_q    <= '0;
      err_q       <= 1'b0;
    end else begin
      seq_open_q  <= seq_open_d;
      prev_vld_q  <= prev_vld_d;
      prev_page_q <= prev_page_d;
      visits_q    <= visits_d;
      err_q       <= err_d;
    end
  end

  assign pass.start = visit_acc && (score || req_i.last_of_seq);
  assign pass.score = score;
  assign pass.last  = req_i.last_of_seq;
  assign pass.clear = visit_acc && seq_new;

  mmsc_engine #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_PAGES    (MAX_PAGES),
    .COST_WIDTH   (COST_WIDTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ld_we_i      (ld_we),
    .ld_cluster_i (CW'(req_i.cluster_index)),
    .ld_from_i    (PW'(req_i.from_page)),
    .ld_to_i      (PW'(req_i.to_page)),
    .ld_cost_i    (COST_WIDTH'(req_i.log_cost)),
    .pass_i       (pass),
    .from_i       (prev_page_q),
    .to_i         (cur_page),
    .nlast_i      (nlast),
    .busy_o       (eng_busy),
    .out_vld_o    (out_vld),
    .out_k_o      (out_k),
    .out_cost_o   (out_cost)
  );

  assign busy        = eng_busy;
  assign res_valid_o = out_vld;

  // visit count and error flag hold until the next visit request after the result
  assign res_o.best_cluster = 4'(out_k);
  assign res_o.best_cost    = out_cost;
  assign res_o.visit_count  = visits_q;
  assign res_o.bad_page     = err_q;

  a_no_pass_on_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_acc |=> !busy)
    else $error("load request made the block busy");

  a_result_closes_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !seq_open_q)
    else $error("result while the sequence is still open");

  a_busy_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (visit_acc && req_i.last_of_seq) |=> busy)
    else $error("last visit did not start a pass");

endmodule
